// ----- rtl/modular_exponentiation_unit_assert.svh -----
// Assertion macros for the modular exponentiation unit.
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside of reset.
`define MEXP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
// Property whose consequent must hold in the cycle after its antecedent.
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MEXP_ASSERT(lbl, prop, msg)
`define MEXP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/mexp_pkg.sv -----
// Shared constants and types of the modular exponentiation unit.
package mexp_pkg;

    // The modulus, a 30-bit prime, and its multiples used by the reduction.
    localparam logic [29:0] PRIME       = 30'd998244353;
    localparam logic [31:0] PRIME_W32   = 32'd998244353;
    localparam logic [31:0] TWO_PRIME   = 32'd1996488706;

    // Barrett reciprocal floor(2^60 / PRIME), which needs 31 bits.
    localparam logic [63:0] MU_FULL     = 64'h1000_0000_0000_0000 / 64'd998244353;
    localparam logic [30:0] MU          = MU_FULL[30:0];

    // Number of exponent bits scanned; bits above the 32-bit field are zero.
    localparam int          EXP_BITS    = 32;
    localparam int          EXP_W       = (EXP_BITS < 32) ? EXP_BITS : 32;
    localparam logic [EXP_W-1:0] INV_EXP = EXP_W'(998244351);

    // Request kinds carried on the input side band.
    localparam logic        REQ_POW     = 1'b0;
    localparam logic        REQ_INV     = 1'b1;

    // Destination of a multiplier result.
    localparam logic        TAG_ACC     = 1'b0;
    localparam logic        TAG_SQ      = 1'b1;

    typedef struct packed {
        logic        valid;
        logic        tag;
        logic [29:0] a;
        logic [29:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        valid;
        logic        tag;
        logic [29:0] res;
    } mul_rsp_t;

endpackage

// ----- rtl/mexp_mulmod.sv -----
// Five-stage pipelined modular multiplier with Barrett reduction.
module mexp_mulmod import mexp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [4:0]  vld_reg;
    logic [4:0]  tag_reg;
    logic [59:0] x_reg;
    logic [59:0] x_next;
    logic [61:0] q2_reg;
    logic [61:0] q2_next;
    logic [31:0] xlo1_reg;
    logic [31:0] xlo2_reg;
    logic [31:0] t_reg;
    logic [31:0] t_next;
    logic [31:0] r_reg;
    logic [31:0] r_next;
    logic [29:0] res_reg;
    logic [29:0] res_next;

    // Full product, then quotient estimate, then the quotient times the prime.
    assign x_next  = 60'(req.a) * 60'(req.b);
    assign q2_next = 62'(x_reg[59:29]) * 62'(MU);
    assign t_next  = 32'(q2_reg[61:31]) * PRIME_W32;
    // The true remainder is below three times the prime, so 32 bits hold it.
    assign r_next  = xlo2_reg - t_reg;

    always_comb begin
        if (r_reg >= TWO_PRIME) begin
            res_next = 30'(r_reg - TWO_PRIME);
        end else if (r_reg >= PRIME_W32) begin
            res_next = 30'(r_reg - PRIME_W32);
        end else begin
            res_next = r_reg[29:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], req.valid};
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg  <= {tag_reg[3:0], req.tag};
        x_reg    <= x_next;
        q2_reg   <= q2_next;
        xlo1_reg <= x_reg[31:0];
        t_reg    <= t_next;
        xlo2_reg <= xlo1_reg;
        r_reg    <= r_next;
        res_reg  <= res_next;
    end

    assign rsp.valid = vld_reg[4];
    assign rsp.tag   = tag_reg[4];
    assign rsp.res   = res_reg;

endmodule

// ----- rtl/modular_exponentiation_unit.sv -----
// Top level of the modular exponentiation unit: sequencer, operand registers and stream ports.
// The unit computes base_value raised to exponent modulo the prime 998244353 by right-to-left
// binary square-and-multiply; a transfer with tuser set asks for the modular inverse instead,
// which uses the exponent 998244351 and ignores the exponent field. A zero exponent gives 1 and
// the inverse of zero gives 0. Every input transfer yields exactly one output transfer. All
// arithmetic runs on one shared modular multiplier. For each scanned exponent bit the
// accumulator multiply and the squaring are issued in consecutive cycles and the sequencer
// waits for both results. The highest set bit needs no squaring. The scan stops after the
// highest set exponent bit. Once the result is loaded into the output register, the
// sequencer returns to idle and can accept the next item in the following cycle. The unit
// takes one item at a time; s_tready is high only while the sequencer is idle. A finished
// result sits in an output register, so a new item may be accepted while the previous
// result still waits for m_tready.
`include "modular_exponentiation_unit_assert.svh"

module modular_exponentiation_unit import mexp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [29:0] base_value, [61:30] exponent, [63:62] zero
    input  logic        s_tuser,   // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [29:0] result_value, [31:30] zero
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_SQR  = 2'd2;
    localparam logic [1:0] ST_WAIT = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [EXP_W-1:0] exp_reg;
    logic [EXP_W-1:0] exp_next;
    logic [29:0]      acc_reg;
    logic [29:0]      acc_next;
    logic [29:0]      sq_reg;
    logic [29:0]      sq_next;
    logic [1:0]       pend_reg;
    logic [1:0]       pend_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [29:0]      m_data_reg;
    logic [29:0]      m_data_next;

    logic             s_xfer;
    logic             out_busy;
    logic             load_out;
    logic [29:0]      base_in;
    logic [29:0]      base_red;
    logic [EXP_W-1:0] exp_in;
    mul_req_t         mul_req;
    mul_rsp_t         mul_rsp;

    mexp_mulmod u_mulmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    // The base field may exceed the prime by less than one modulus, so one subtraction reduces it.
    assign base_in  = s_tdata[29:0];
    assign base_red = (base_in >= PRIME) ? (base_in - PRIME) : base_in;
    assign exp_in   = (s_tuser == REQ_INV) ? INV_EXP : s_tdata[30 +: EXP_W];

    // The output register is free unless it holds a result that is not being taken.
    assign out_busy = m_valid_reg && !m_tready;
    assign load_out = (state_reg == ST_RUN) && (exp_reg == '0) && !out_busy;

    // Multiplier issue: the accumulator multiply in the run state when the current bit is set,
    // and the squaring in the following cycle when higher bits remain to be scanned.
    always_comb begin
        mul_req.valid = 1'b0;
        mul_req.tag   = TAG_ACC;
        mul_req.a     = acc_reg;
        mul_req.b     = sq_reg;
        unique case (state_reg)
            ST_RUN: begin
                mul_req.valid = (exp_reg != '0) && exp_reg[0];
            end
            ST_SQR: begin
                mul_req.valid = (exp_reg[EXP_W-1:1] != '0);
                mul_req.tag   = TAG_SQ;
                mul_req.a     = sq_reg;
            end
            default: begin
                mul_req.valid = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        exp_next   = exp_reg;
        acc_next   = acc_reg;
        sq_next    = sq_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_RUN;
                    exp_next   = exp_in;
                    acc_next   = 30'd1;
                    sq_next    = base_red;
                end
            end
            ST_RUN: begin
                if (exp_reg != '0) begin
                    state_next = ST_SQR;
                end else if (!out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_SQR: begin
                exp_next   = exp_reg >> 1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (pend_reg == 2'd0) begin
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        // Results return only while waiting, never on the cycle of a new load.
        if (mul_rsp.valid) begin
            if (mul_rsp.tag == TAG_ACC) begin
                acc_next = mul_rsp.res;
            end else begin
                sq_next = mul_rsp.res;
            end
        end
    end

    assign pend_next    = 2'(pend_reg + {1'b0, mul_req.valid} - {1'b0, mul_rsp.valid});
    assign m_valid_next = load_out || out_busy;
    assign m_data_next  = load_out ? acc_reg : m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pend_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_data_reg};

    // Multiplier results may only arrive while the sequencer waits for them.
    `MEXP_ASSERT(a_rsp_in_wait, mul_rsp.valid |-> state_reg == ST_WAIT, "result outside wait state")
    // No multiply may still be in flight once the sequencer is idle.
    `MEXP_ASSERT(a_idle_drained, state_reg == ST_IDLE |-> pend_reg == 2'd0, "pending multiply")
    // A completed item presents a fully reduced result in the following cycle.
    `MEXP_ASSERT_NEXT(a_out_reduced, load_out, m_tvalid && m_tdata[29:0] < PRIME, "bad result")

endmodule
